FILE: src/rtcas_pkg.sv
// ----------------------------------------------------------------------------
// rtcas_pkg: shared constants and types of the cellular automaton step unit
// Row geometry, register indexes, rule field layout and the configuration
// bundle that the lanes read.
// ----------------------------------------------------------------------------
`default_nettype none
package rtcas_pkg;

  localparam int ROW_CELLS       = 32;
  localparam int RULES_PER_STATE = 4;
  localparam int STATE_COUNT     = 4;

  localparam int CELL_W        = 2;
  localparam int ROW_W         = 64;
  localparam int LINE_W        = ROW_CELLS * CELL_W;
  localparam int WIN_W         = 3 * CELL_W;
  localparam int RULE_W        = 16;
  localparam int NUM_RULE_REGS = 4;
  localparam int NBR_W         = 4;
  localparam int CFG_IDX_W     = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NBR_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALIVE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RULES0   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RULES1   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RULES2   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RULES3   = 3'd6;

  // rule compare codes
  localparam logic [2:0] OP_EQ = 3'd0;
  localparam logic [2:0] OP_GT = 3'd1;
  localparam logic [2:0] OP_LT = 3'd2;
  localparam logic [2:0] OP_GE = 3'd3;
  localparam logic [2:0] OP_LE = 3'd4;

  // neighborhood codes
  localparam logic NBR_MOORE = 1'b0;

  typedef struct packed {
    logic                                nbr_mode;
    logic [CELL_W-1:0]                   alive;
    logic [CELL_W-1:0]                   dead;
    logic [NUM_RULE_REGS-1:0][ROW_W-1:0] rules;
  } cfg_t;

endpackage
`default_nettype wire

FILE: src/rtcas_if.sv
// ----------------------------------------------------------------------------
// rtcas_if: row channels of the cellular automaton step unit
// Input word carries one grid row, output word carries one evolved row.
// ----------------------------------------------------------------------------
`default_nettype none
interface rtcas_in_if import rtcas_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_cells;
  logic             last_row;

  modport source (output valid, output row_cells, output last_row, input ready);
  modport sink   (input valid, input row_cells, input last_row, output ready);
endinterface

interface rtcas_out_if import rtcas_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] next_row;
  logic             frame_end;

  modport source (output valid, output next_row, output frame_end, input ready);
  modport sink   (input valid, input next_row, input frame_end, output ready);
endinterface
`default_nettype wire

FILE: src/rtcas_lane.sv
// ----------------------------------------------------------------------------
// rtcas_lane: next state of one cell
// Count live neighbors in a 3x3 window, then apply the cell's rule list.
// ----------------------------------------------------------------------------
`default_nettype none
module rtcas_lane import rtcas_pkg::*; (
  input  cfg_t              cfg,
  input  logic [WIN_W-1:0]  up_win,
  input  logic [WIN_W-1:0]  mid_win,
  input  logic [WIN_W-1:0]  lo_win,
  output logic [CELL_W-1:0] cell_next
);

  logic [NBR_W-1:0]  n;
  logic [CELL_W-1:0] ctr;
  logic [ROW_W-1:0]  rs;
  logic [RULE_W-1:0] rule;

  function automatic logic rule_hit(input logic [2:0] op, input logic [NBR_W-1:0] cnt,
                                    input logic [3:0] num);
    logic hit;
    case (op)
      OP_EQ:   hit = (cnt == num);
      OP_GT:   hit = (cnt > num);
      OP_LT:   hit = (cnt < num);
      OP_GE:   hit = (cnt >= num);
      OP_LE:   hit = (cnt <= num);
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  always_comb begin
    n = '0;
    n = n + NBR_W'(up_win[3:2] == cfg.alive);
    n = n + NBR_W'(lo_win[3:2] == cfg.alive);
    n = n + NBR_W'(mid_win[1:0] == cfg.alive);
    n = n + NBR_W'(mid_win[5:4] == cfg.alive);
    if (cfg.nbr_mode == NBR_MOORE) begin
      n = n + NBR_W'(up_win[1:0] == cfg.alive);
      n = n + NBR_W'(up_win[5:4] == cfg.alive);
      n = n + NBR_W'(lo_win[1:0] == cfg.alive);
      n = n + NBR_W'(lo_win[5:4] == cfg.alive);
    end

    ctr       = mid_win[3:2];
    cell_next = ctr;
    rs        = cfg.rules[ctr];
    rule      = '0;
    if (int'(ctr) < STATE_COUNT) begin
      // later rules override earlier ones
      for (int k = 0; k < RULES_PER_STATE; k++) begin
        rule = rs[k*RULE_W +: RULE_W];
        if (rule[15] && (int'(rule[1:0]) < STATE_COUNT) &&
            rule_hit(rule[10:8], n, rule[7:4])) begin
          cell_next = rule[1:0];
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/rtcas_array.sv
// ----------------------------------------------------------------------------
// rtcas_array: row of cell lanes and merge into one output row
// Pad each row with the dead state at both edges and give each lane its window.
// ----------------------------------------------------------------------------
`default_nettype none
module rtcas_array import rtcas_pkg::*; (
  input  cfg_t              cfg,
  input  logic [LINE_W-1:0] up_line,
  input  logic [LINE_W-1:0] mid_line,
  input  logic [LINE_W-1:0] lo_line,
  output logic [ROW_W-1:0]  next_row
);

  logic [LINE_W+2*CELL_W-1:0] up_pad;
  logic [LINE_W+2*CELL_W-1:0] mid_pad;
  logic [LINE_W+2*CELL_W-1:0] lo_pad;
  logic [LINE_W-1:0]          lanes;

  assign up_pad  = {cfg.dead, up_line, cfg.dead};
  assign mid_pad = {cfg.dead, mid_line, cfg.dead};
  assign lo_pad  = {cfg.dead, lo_line, cfg.dead};

  for (genvar c = 0; c < ROW_CELLS; c++) begin : g_lane
    rtcas_lane u_lane (
      .cfg       (cfg),
      .up_win    (up_pad[c*CELL_W +: WIN_W]),
      .mid_win   (mid_pad[c*CELL_W +: WIN_W]),
      .lo_win    (lo_pad[c*CELL_W +: WIN_W]),
      .cell_next (lanes[c*CELL_W +: CELL_W])
    );
  end

  // merge: lanes fill the low bits, unused cells read as zero
  always_comb begin
    next_row             = '0;
    next_row[LINE_W-1:0] = lanes;
  end

endmodule
`default_nettype wire

FILE: src/rule_table_cellular_automaton_step_unit.sv
// ----------------------------------------------------------------------------
// rule_table_cellular_automaton_step_unit: one-generation row stencil
// A row's word passes the job stage and output register once the row below is taken.
// One row per cycle unless the output stalls; a multi-row frame's last row gives two words.
// Reset clears rows_held, pending and valid flags; cfg registers take reset values.
// ----------------------------------------------------------------------------
`default_nettype none
module rule_table_cellular_automaton_step_unit import rtcas_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  rtcas_in_if.sink             in_row,
  rtcas_out_if.source          out_row,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ROW_W-1:0]     cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nbr_mode <= NBR_MOORE;
      cfg.alive    <= CELL_W'(1);
      cfg.dead     <= '0;
      cfg.rules    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NBR_MODE: cfg.nbr_mode <= cfg_data[0];
        REG_ALIVE:    cfg.alive    <= cfg_data[CELL_W-1:0];
        REG_DEAD:     cfg.dead     <= cfg_data[CELL_W-1:0];
        REG_RULES0:   cfg.rules[0] <= cfg_data;
        REG_RULES1:   cfg.rules[1] <= cfg_data;
        REG_RULES2:   cfg.rules[2] <= cfg_data;
        REG_RULES3:   cfg.rules[3] <= cfg_data;
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  // a row made entirely of the dead state, for edges above and below the grid
  logic [LINE_W-1:0] dead_line;
  assign dead_line = {ROW_CELLS{cfg.dead}};

  // --------------------------------------------------------------------------
  // Row history: two rows back, plus how many of them are live in the frame
  // --------------------------------------------------------------------------
  logic [LINE_W-1:0] upper_row;
  logic [LINE_W-1:0] middle_row;
  logic [1:0]        rows_held;
  logic [LINE_W-1:0] in_line;

  assign in_line = in_row.row_cells[LINE_W-1:0];

  // --------------------------------------------------------------------------
  // Job stage: three rows waiting for the lanes. It parts the input from the
  // output register, so a row is taken while a finished word waits.
  // pending marks the second word of a last row, built from the history.
  // --------------------------------------------------------------------------
  logic              job_valid;
  logic [LINE_W-1:0] job_up;
  logic [LINE_W-1:0] job_mid;
  logic [LINE_W-1:0] job_lo;
  logic              job_end;
  logic              pending;

  logic out_adv;
  logic job_free;
  logic in_acc;

  assign out_adv      = !out_row.valid || out_row.ready;
  assign job_free     = !job_valid || out_adv;
  assign in_row.ready = job_free && !pending;
  assign in_acc       = in_row.valid && in_row.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_held <= '0;
      pending   <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      if (pending && job_free) begin
        // second word of the last row: the row below is outside the grid
        job_valid <= 1'b1;
        job_up    <= upper_row;
        job_mid   <= middle_row;
        job_lo    <= dead_line;
        job_end   <= 1'b1;
        pending   <= 1'b0;
      end else if (in_acc) begin
        if (rows_held == 2'd0) begin
          middle_row <= in_line;
          if (in_row.last_row) begin
            // single-row frame: dead above and below, one word
            job_valid <= 1'b1;
            job_up    <= dead_line;
            job_mid   <= in_line;
            job_lo    <= dead_line;
            job_end   <= 1'b1;
          end else begin
            // first row of the frame: hold it, nothing to evolve yet
            job_valid <= 1'b0;
            rows_held <= 2'd1;
          end
        end else begin
          // evolve the held middle row; a first row sees dead above it
          job_valid  <= 1'b1;
          job_up     <= (rows_held == 2'd1) ? dead_line : upper_row;
          job_mid    <= middle_row;
          job_lo     <= in_line;
          job_end    <= 1'b0;
          upper_row  <= middle_row;
          middle_row <= in_line;
          if (in_row.last_row) begin
            pending   <= 1'b1;
            rows_held <= 2'd0;
          end else begin
            rows_held <= 2'd2;
          end
        end
      end else if (job_free) begin
        job_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Lanes: one per cell, merged into a packed row
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0] lane_row;

  rtcas_array u_array (
    .cfg      (cfg),
    .up_line  (job_up),
    .mid_line (job_mid),
    .lo_line  (job_lo),
    .next_row (lane_row)
  );

  // --------------------------------------------------------------------------
  // Output register: advance when empty or taken, hold otherwise
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_row.valid <= 1'b0;
    end else if (out_adv) begin
      out_row.valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && job_valid) begin
      out_row.next_row  <= lane_row;
      out_row.frame_end <= job_end;
    end
  end

endmodule
`default_nettype wire

FILE: test/rtcas_generation_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtcas_generation_monitor: next-generation row prediction and checking
// Follows register writes and accepted rows, computes the rows that the step
// unit owes, and compares every output word with the oldest one still due.
// ----------------------------------------------------------------------------
module rtcas_generation_monitor import rtcas_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  rtcas_in_if                  in_mon,
  rtcas_out_if                 out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ROW_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   words_pending
);

  typedef struct {
    logic [ROW_W-1:0] next_row;
    logic             frame_end;
  } due_row_t;

  due_row_t         next_rows_due[$];
  cfg_t             regs;
  logic [ROW_W-1:0] row_above;
  logic [ROW_W-1:0] row_current;
  int               rows_buffered;
  int               words_seen;

  initial begin
    fail_count    = 0;
    words_pending = 0;
    words_seen    = 0;
  end

  // cells beyond either edge of the row read as the border state
  function automatic logic [CELL_W-1:0] cell_at(input logic [ROW_W-1:0] row, input int col);
    if (col < 0 || col >= ROW_CELLS) begin
      return regs.dead;
    end
    return row[CELL_W*col +: CELL_W];
  endfunction

  function automatic logic [ROW_W-1:0] border_row();
    logic [ROW_W-1:0] r;
    r = '0;
    for (int c = 0; c < ROW_CELLS; c++) begin
      r[CELL_W*c +: CELL_W] = regs.dead;
    end
    return r;
  endfunction

  function automatic bit rule_fires(input logic [2:0] op, input int n, input logic [3:0] num);
    int limit;
    limit = int'(num);
    case (op)
      OP_EQ:   return n == limit;
      OP_GT:   return n > limit;
      OP_LT:   return n < limit;
      OP_GE:   return n >= limit;
      OP_LE:   return n <= limit;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [ROW_W-1:0] evolve_row(input logic [ROW_W-1:0] up,
                                                  input logic [ROW_W-1:0] mid,
                                                  input logic [ROW_W-1:0] lo);
    logic [ROW_W-1:0]  result;
    logic [RULE_W-1:0] rule;
    logic [CELL_W-1:0] s;
    logic [CELL_W-1:0] ns;
    int                n;
    result = '0;
    for (int c = 0; c < ROW_CELLS; c++) begin
      s = cell_at(mid, c);
      n = int'(cell_at(up, c) == regs.alive) + int'(cell_at(lo, c) == regs.alive) +
          int'(cell_at(mid, c - 1) == regs.alive) + int'(cell_at(mid, c + 1) == regs.alive);
      if (regs.nbr_mode == NBR_MOORE) begin
        n += int'(cell_at(up, c - 1) == regs.alive) + int'(cell_at(up, c + 1) == regs.alive) +
             int'(cell_at(lo, c - 1) == regs.alive) + int'(cell_at(lo, c + 1) == regs.alive);
      end
      if (int'(s) < STATE_COUNT) begin
        ns = s;
        // last matching rule wins
        for (int k = 0; k < RULES_PER_STATE && k < 4; k++) begin
          rule = regs.rules[s][RULE_W*k +: RULE_W];
          if (rule[15] && int'(rule[1:0]) < STATE_COUNT && rule_fires(rule[10:8], n, rule[7:4]))
          begin
            ns = rule[1:0];
          end
        end
        s = ns;
      end
      result[CELL_W*c +: CELL_W] = s;
    end
    return result;
  endfunction

  task automatic owe_row(input logic [ROW_W-1:0] cells, input logic last);
    due_row_t d;
    d.next_row    = cells;
    d.frame_end   = last;
    next_rows_due = {next_rows_due, d};
  endtask

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin : track
    due_row_t         want;
    logic [ROW_W-1:0] border;
    if (rst) begin
      regs.nbr_mode = NBR_MOORE;
      regs.alive    = 2'd1;
      regs.dead     = 2'd0;
      regs.rules    = '0;
      rows_buffered = 0;
      next_rows_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NBR_MODE: regs.nbr_mode = cfg_data[0];
          REG_ALIVE:    regs.alive    = cfg_data[CELL_W-1:0];
          REG_DEAD:     regs.dead     = cfg_data[CELL_W-1:0];
          REG_RULES0:   regs.rules[0] = cfg_data;
          REG_RULES1:   regs.rules[1] = cfg_data;
          REG_RULES2:   regs.rules[2] = cfg_data;
          REG_RULES3:   regs.rules[3] = cfg_data;
          default: ;
        endcase
      end
      border = border_row();
      if (in_mon.valid && in_mon.ready) begin
        if (rows_buffered == 0) begin
          row_current   = in_mon.row_cells;
          rows_buffered = 1;
          if (in_mon.last_row) begin
            owe_row(evolve_row(border, in_mon.row_cells, border), 1'b1);
            rows_buffered = 0;
          end
        end else begin
          owe_row(evolve_row(rows_buffered >= 2 ? row_above : border, row_current,
                             in_mon.row_cells), 1'b0);
          row_above     = row_current;
          row_current   = in_mon.row_cells;
          rows_buffered = 2;
          if (in_mon.last_row) begin
            owe_row(evolve_row(row_above, row_current, border), 1'b1);
            rows_buffered = 0;
          end
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        words_seen++;
        if (next_rows_due.size() == 0) begin
          report_mismatch($sformatf("word %0d arrived with no row due", words_seen));
        end else begin
          want = next_rows_due.pop_front();
          if (out_mon.next_row !== want.next_row) begin
            report_mismatch($sformatf("word %0d next_row %h, want %h", words_seen,
                                      out_mon.next_row, want.next_row));
          end
          if (out_mon.frame_end !== want.frame_end) begin
            report_mismatch($sformatf("word %0d frame_end %b, want %b", words_seen,
                                      out_mon.frame_end, want.frame_end));
          end
        end
      end
    end
    words_pending <= next_rows_due.size();
  end

endmodule

FILE: test/rule_table_cellular_automaton_step_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rule_table_cellular_automaton_step_unit_test: stimulus and verdict
// Streams frames of grid rows through the step unit under a range of rule
// tables and neighborhoods, with random idle cycles on both channels and one
// long output stall; a side monitor predicts every evolved row and counts
// mismatches.
// ----------------------------------------------------------------------------
module rule_table_cellular_automaton_step_unit_test;
  import rtcas_pkg::*;

  localparam int ROW_TARGET      = 1150;  // stop launching frames past this many rows
  localparam int IDLE_PERCENT    = 16;
  localparam int HOLD_OFF_CYCLES = 300;   // one long output stall to back up the unit
  localparam int SETTLE_CYCLES   = 4;     // leave a margin before writes
  localparam int TAIL_CYCLES     = 20;
  localparam int WATCHDOG_LIMIT  = 2000;

  // a compare code outside the defined set; such a rule never fires
  localparam logic [2:0] OP_BOGUS = 3'd7;

  typedef enum int {RULES_SHAPED, RULES_RAW, RULES_EXTREME} rule_style_e;
  typedef enum int {ROW_NOISE, ROW_SPARSE, ROW_FLAT} row_style_e;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ROW_W-1:0]     cfg_data;

  rtcas_in_if  in_ch ();
  rtcas_out_if out_ch ();

  int   fail_count;
  int   words_pending;
  int   rows_sent = 0;
  int   stall_cycles = 0;
  bit   in_gaps_on = 1'b1;
  bit   out_gaps_on = 1'b1;
  bit   hold_off_req = 1'b0;
  cfg_t setting;  // what the registers hold now; shapes the sparse rows

  rule_table_cellular_automaton_step_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_row    (in_ch),
    .out_row   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rtcas_generation_monitor row_check (
    .clk           (clk),
    .rst           (rst),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  always #10 clk = ~clk;

  // Watchdog: count cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Output side: drop ready at random, or hold it low for a long stretch
  // when asked, while the sender keeps offering rows.
  initial begin : sink_side
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ch.ready <= !(out_gaps_on && $urandom_range(99) < IDLE_PERCENT);
    end
  end

  function automatic logic [RULE_W-1:0] make_rule(input bit on, input logic [2:0] op,
                                                  input logic [3:0] num,
                                                  input logic [CELL_W-1:0] next_state);
    return {on, 4'b0000, op, num, 2'b00, next_state};
  endfunction

  // Mostly sensible rules; now and then an unknown compare code or a count
  // beyond what a neighborhood can reach.
  function automatic logic [RULE_W-1:0] random_rule();
    logic [2:0] op;
    logic [3:0] num;
    op  = ($urandom_range(9) == 0) ? 3'($urandom_range(OP_BOGUS, OP_LE + 3'd1))
                                   : 3'($urandom_range(OP_LE));
    num = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
    return make_rule($urandom_range(7) != 0, op, num, 2'($urandom_range(3)));
  endfunction

  function automatic cfg_t random_setting(input rule_style_e style);
    cfg_t c;
    c.nbr_mode = 1'($urandom_range(1));
    c.alive    = 2'($urandom_range(3));
    c.dead     = ($urandom_range(4) == 0) ? c.alive : 2'($urandom_range(3));
    if (style == RULES_EXTREME) begin
      c.alive = $urandom_range(1) ? 2'b11 : 2'b00;
      c.dead  = $urandom_range(1) ? 2'b11 : 2'b00;
    end
    for (int s = 0; s < NUM_RULE_REGS; s++) begin
      for (int k = 0; k < 4; k++) begin
        c.rules[s][RULE_W*k +: RULE_W] = random_rule();
      end
      if (style == RULES_RAW) begin
        c.rules[s] = {$urandom, $urandom};
      end else if (style == RULES_EXTREME && $urandom_range(2) != 0) begin
        c.rules[s] = $urandom_range(1) ? '1 : '0;
      end
    end
    return c;
  endfunction

  function automatic logic [ROW_W-1:0] random_row(input row_style_e style);
    logic [ROW_W-1:0]  r;
    logic [CELL_W-1:0] fill;
    r    = {$urandom, $urandom};
    fill = 2'($urandom_range(3));
    for (int c = 0; c < ROW_CELLS; c++) begin
      if (style == ROW_FLAT) begin
        r[CELL_W*c +: CELL_W] = fill;
      end else if (style == ROW_SPARSE && $urandom_range(9) != 0) begin
        r[CELL_W*c +: CELL_W] = ($urandom_range(2) == 0) ? setting.alive : setting.dead;
      end
    end
    return r;
  endfunction

  // Offer one row; idle first at random. Leave valid high on return so the
  // next row can follow back to back.
  task automatic send_row(input logic [ROW_W-1:0] cells, input logic last);
    while (in_gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.row_cells <= cells;
    in_ch.last_row  <= last;
    do @(posedge clk); while (!in_ch.ready);
    rows_sent++;
  endtask

  // Drop valid, wait for every owed word, then let the pipeline go quiet.
  task automatic wait_until_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [ROW_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Write all registers; the narrow ones carry random junk above their field.
  task automatic program_regs(input cfg_t c);
    logic [ROW_W-1:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_NBR_MODE, {junk[ROW_W-1:1], c.nbr_mode});
    write_reg(REG_ALIVE, {junk[ROW_W-1:CELL_W], c.alive});
    write_reg(REG_DEAD, {~junk[ROW_W-1:CELL_W], c.dead});
    write_reg(REG_RULES0, c.rules[0]);
    write_reg(REG_RULES1, c.rules[1]);
    write_reg(REG_RULES2, c.rules[2]);
    write_reg(REG_RULES3, c.rules[3]);
    cfg_we  <= 1'b0;
    setting = c;
  endtask

  initial begin : stimulus
    cfg_t       plan;
    int         phase;
    int         height;
    row_style_e kind;

    in_ch.valid     <= 1'b0;
    in_ch.row_cells <= '0;
    in_ch.last_row  <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_NBR_MODE;
    cfg_data        <= '0;
    setting.nbr_mode = NBR_MOORE;
    setting.alive    = 2'd1;
    setting.dead     = 2'd0;
    setting.rules    = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset registers have empty rule lists: a lone row comes back as is.
    send_row(64'h0123_4567_89AB_CDEF, 1'b1);
    wait_until_drained();

    // Life-like table with traps: an invalid rule that would match, an unknown
    // compare code, counts above eight, and rules that override earlier ones.
    plan.nbr_mode = NBR_MOORE;
    plan.alive    = 2'd1;
    plan.dead     = 2'd0;
    plan.rules[0] = {make_rule(1'b1, OP_EQ, 4'd9, 2'd2), make_rule(1'b1, OP_BOGUS, 4'd0, 2'd3),
                     make_rule(1'b0, OP_GE, 4'd0, 2'd2), make_rule(1'b1, OP_EQ, 4'd3, 2'd1)};
    plan.rules[1] = {make_rule(1'b1, OP_LE, 4'd1, 2'd2), make_rule(1'b1, OP_GE, 4'd12, 2'd3),
                     make_rule(1'b1, OP_GT, 4'd3, 2'd0), make_rule(1'b1, OP_LT, 4'd2, 2'd0)};
    plan.rules[2] = {make_rule(1'b1, OP_LE, 4'd0, 2'd0), make_rule(1'b1, OP_GE, 4'd4, 2'd3),
                     32'h0};
    plan.rules[3] = {make_rule(1'b1, OP_EQ, 4'd8, 2'd0), make_rule(1'b1, OP_LE, 4'd15, 2'd1),
                     make_rule(1'b1, OP_GT, 4'd15, 2'd2), make_rule(1'b0, OP_EQ, 4'd0, 2'd2)};
    program_regs(plan);

    // single-row frames at both extremes of the row
    send_row('1, 1'b1);
    send_row('0, 1'b1);
    // all live, all top state, all state two: three rows
    send_row(64'h5555_5555_5555_5555, 1'b0);
    send_row('1, 1'b0);
    send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    // two-row frame with live cells on both edges
    send_row(64'h4000_0000_0000_0005, 1'b0);
    send_row(64'h4000_0000_0000_0001, 1'b1);
    // vertical blinker in a five-row frame
    send_row('0, 1'b0);
    send_row(64'h0000_0000_0000_0400, 1'b0);
    send_row(64'h0000_0000_0000_0400, 1'b0);
    send_row(64'h0000_0000_0000_0400, 1'b0);
    send_row('0, 1'b1);
    wait_until_drained();

    // Change registers mid-frame: the first row is held, nothing is owed.
    send_row(64'h5555_0000_FFFF_1111, 1'b0);
    wait_until_drained();
    plan          = random_setting(RULES_SHAPED);
    plan.nbr_mode = ~NBR_MOORE;
    plan.alive    = 2'd2;
    plan.dead     = 2'd2;  // border counts as live
    program_regs(plan);
    send_row(random_row(ROW_SPARSE), 1'b0);
    send_row(random_row(ROW_NOISE), 1'b1);
    wait_until_drained();

    // Top state as live and border state, rule words all ones: every rule has a bogus code.
    plan.nbr_mode = NBR_MOORE;
    plan.alive    = 2'd3;
    plan.dead     = 2'd3;
    plan.rules    = '1;
    program_regs(plan);
    send_row(random_row(ROW_SPARSE), 1'b0);
    send_row(random_row(ROW_NOISE), 1'b1);
    wait_until_drained();

    plan          = random_setting(RULES_SHAPED);
    plan.nbr_mode = ~NBR_MOORE;
    plan.alive    = 2'd0;
    plan.dead     = 2'd3;
    program_regs(plan);
    send_row(random_row(ROW_FLAT), 1'b0);
    send_row(random_row(ROW_SPARSE), 1'b0);
    send_row(random_row(ROW_NOISE), 1'b1);

    // Random phases: fresh registers, then a handful of frames each.
    phase = 0;
    while (rows_sent < ROW_TARGET) begin
      wait_until_drained();
      program_regs(random_setting(rule_style_e'(phase % 3)));
      // one stretch with no idling on either side
      in_gaps_on  = (phase != 4 && phase != 5);
      out_gaps_on = in_gaps_on;
      if (phase == 7) begin
        hold_off_req = 1'b1;
      end
      repeat (6) begin
        case ($urandom_range(9))
          0, 1:    height = 1;
          2, 3:    height = $urandom_range(24, 9);
          default: height = $urandom_range(8, 2);
        endcase
        kind = row_style_e'($urandom_range(9) < 6 ? ROW_SPARSE : $urandom_range(ROW_FLAT));
        for (int r = 0; r < height; r++) begin
          // now and then swap registers while a row is held
          if (r == 1 && $urandom_range(9) == 0) begin
            wait_until_drained();
            program_regs(random_setting(rule_style_e'($urandom_range(RULES_EXTREME))));
          end
          send_row(random_row(kind), r == height - 1);
        end
      end
      phase++;
    end

    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
